// ----- sv/bsf_pkg.sv -----
// Boot slot failover package: record constants, config register indexes
// and the CRC-32 helpers. No dependencies.
package bsf_pkg;

  localparam logic [31:0] REC_MAGIC   = 32'hAD1B007C;
  localparam logic [31:0] REC_VERSION = 32'h00000001;
  localparam logic [7:0]  BYTE_MAX    = 8'hFF;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_FIRST   = 3'd0,
    REG_SLOT_LAST    = 3'd1,
    REG_COUNT_LIMIT  = 3'd2,
    REG_CAUSE_NONE   = 3'd3,
    REG_CAUSE_VERIFY = 3'd4
  } cfg_reg_e;

  // Register after 32 shift steps seeded with a single set bit; constant folded.
  function automatic logic [31:0] crc_unit(input int unsigned bit_idx);
    logic [31:0] c;
    c = 32'd1 << bit_idx;
    for (int unsigned k = 0; k < 32; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // One word through the reflected CRC: linear in (crc ^ word), so an XOR matrix.
  function automatic logic [31:0] crc_lin(input logic [31:0] x);
    logic [31:0] r;
    r = '0;
    for (int unsigned i = 0; i < 32; i++) begin
      r = r ^ (x[i] ? crc_unit(i) : 32'd0);
    end
    return r;
  endfunction

  function automatic logic [31:0] record_crc(input logic [31:0] magic,
                                             input logic [31:0] version,
                                             input logic [31:0] slot);
    logic [31:0] c;
    c = crc_lin(CRC_INIT ^ magic);
    c = crc_lin(c ^ version);
    c = crc_lin(c ^ slot);
    return ~c;
  endfunction

  // CRC state after the fixed magic and version words
  localparam logic [31:0] CRC_HEAD = crc_lin(crc_lin(CRC_INIT ^ REC_MAGIC) ^ REC_VERSION);

  typedef struct packed {
    logic [7:0]  chosen_slot;
    logic        record_ok;
    logic        write_back;
    logic [31:0] new_record_check;
    logic        recovery_on;
    logic [7:0]  attempt_count;
    logic        halt;
  } result_t;

endpackage

// ----- sv/boot_slot_failover_unit.sv -----
// Boot slot failover unit: record check, slot fallback and failover state.
// Depends on bsf_pkg.
//
// Input transaction to result passes the input register and then the result
// register; throughput one event per cycle, with full back-pressure.
// The record CRC is checked ahead of the input register; state update and the
// write-back CRC sit between input and result registers.
// Async active-low reset: config to defaults, failover state and valids cleared.
module boot_slot_failover_unit
  import bsf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  // event input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // record_magic[31:0], record_version[63:32], record_slot[95:64],
  // record_check[127:96], secure_cause[159:128], nonsecure_cause[191:160]
  input  logic [191:0]         s_axis_tdata,
  // record_read_ok[0]
  input  logic                 s_axis_tuser,
  // result output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // chosen_slot[7:0], record_ok[8], write_back[9], new_record_check[41:10],
  // recovery_on[42], attempt_count[50:43], halt[51], zero pad [55:52]
  output logic [55:0]          m_axis_tdata
);

  // configuration
  logic [7:0]  slot_first_q, slot_last_q, count_limit_q;
  logic [31:0] cause_none_q, cause_verify_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_first_q   <= 8'd97;
      slot_last_q    <= 8'd98;
      count_limit_q  <= 8'd3;
      cause_none_q   <= 32'd0;
      cause_verify_q <= 32'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SLOT_FIRST:   slot_first_q   <= cfg_data_i[7:0];
        REG_SLOT_LAST:    slot_last_q    <= cfg_data_i[7:0];
        REG_COUNT_LIMIT:  count_limit_q  <= cfg_data_i[7:0];
        REG_CAUSE_NONE:   cause_none_q   <= cfg_data_i;
        REG_CAUSE_VERIFY: cause_verify_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic        in_valid_q;
  logic        in_chk_ok_q;
  logic [7:0]  in_slot_q;
  logic [31:0] in_cause_s_q, in_cause_ns_q;
  logic        in_chk_ok_d;
  logic        res_valid_q;
  logic        res_load;
  logic        advance_in;

  assign res_load      = !res_valid_q || m_axis_tready;
  assign advance_in    = in_valid_q && res_load;
  assign s_axis_tready = !in_valid_q || res_load;

  assign in_chk_ok_d = s_axis_tuser
                    && (s_axis_tdata[31:0] == REC_MAGIC)
                    && (s_axis_tdata[63:32] == REC_VERSION)
                    && (s_axis_tdata[127:96] == record_crc(s_axis_tdata[31:0],
                                                           s_axis_tdata[63:32],
                                                           s_axis_tdata[95:64]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_chk_ok_q   <= in_chk_ok_d;
      in_slot_q     <= s_axis_tdata[71:64];
      in_cause_s_q  <= s_axis_tdata[159:128];
      in_cause_ns_q <= s_axis_tdata[191:160];
    end
  end

  // failover state
  logic [7:0] last_slot_q, last_slot_d;
  logic [7:0] first_seen_q, first_seen_d;
  logic [7:0] count_q, count_d;
  logic       armed_q, armed_d;
  result_t    res_q, res_d;

  function automatic logic in_range(input logic [7:0] s, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (s >= lo) && (s <= hi);
  endfunction

  logic       rec_ok, wb_fb, fail, verify, adv, nxt_ok;
  logic [7:0] fallback, active0, starting, cnt_inc, nxt, active;
  logic [8:0] nxt_wide;

  always_comb begin
    rec_ok   = in_chk_ok_q && in_range(in_slot_q, slot_first_q, slot_last_q);
    fallback = (last_slot_q != 8'd0) ? last_slot_q : slot_first_q;
    wb_fb    = !rec_ok && in_range(fallback, slot_first_q, slot_last_q);
    active0  = rec_ok ? in_slot_q : fallback;
    starting = (first_seen_q == 8'd0) ? active0 : first_seen_q;

    fail    = (in_cause_s_q != cause_none_q) || (in_cause_ns_q != cause_none_q);
    verify  = (in_cause_s_q == cause_verify_q) || (in_cause_ns_q == cause_verify_q);
    cnt_inc = (count_q < BYTE_MAX) ? count_q + 8'd1 : count_q;
    adv     = fail && (verify || (cnt_inc >= count_limit_q));

    // step past slot_last (including from 255) wraps to slot_first
    nxt_wide = {1'b0, active0} + 9'd1;
    nxt      = (nxt_wide > {1'b0, slot_last_q}) ? slot_first_q : nxt_wide[7:0];
    nxt_ok   = in_range(nxt, slot_first_q, slot_last_q);

    active       = (adv && nxt_ok) ? nxt : active0;
    last_slot_d  = (adv && nxt_ok) ? nxt : (wb_fb ? fallback : last_slot_q);
    first_seen_d = starting;
    count_d      = fail ? (adv ? 8'd0 : cnt_inc) : count_q;
    armed_d      = armed_q || (adv && (nxt == starting));

    res_d.chosen_slot      = active;
    res_d.record_ok        = rec_ok;
    res_d.write_back       = wb_fb || (adv && nxt_ok);
    res_d.new_record_check = ~crc_lin(CRC_HEAD ^ {24'd0, active});
    res_d.recovery_on      = armed_d;
    res_d.attempt_count    = count_d;
    res_d.halt             = adv && (nxt == starting) && armed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_slot_q  <= 8'd0;
      first_seen_q <= 8'd0;
      count_q      <= 8'd0;
      armed_q      <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (advance_in) begin
        last_slot_q  <= last_slot_d;
        first_seen_q <= first_seen_d;
        count_q      <= count_d;
        armed_q      <= armed_d;
      end
      if (res_load) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_in) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {4'd0, res_q.halt, res_q.attempt_count, res_q.recovery_on,
                          res_q.new_record_check, res_q.write_back, res_q.record_ok,
                          res_q.chosen_slot};

`ifndef NO_ASSERTIONS
  // halt only once recovery has been armed
  a_halt_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.halt) |-> res_q.recovery_on)
    else $error("halt reported without recovery armed");

  // a recovery flag, once set, never drops
  a_armed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(armed_q) |-> armed_q)
    else $error("recovery flag cleared");

  // the starting slot is recorded by the first transaction and then frozen
  a_first_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(first_seen_q) != 8'd0) |-> (first_seen_q == $past(first_seen_q)))
    else $error("starting slot changed after being recorded");

  // a stalled result is not overwritten by the state path
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !advance_in)
    else $error("result register overwritten while stalled");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Testbench for boot_slot_failover_unit: directed and random boot events,
// a cycle-free predictor of the slot failover decision, and a result checker.
// Depends on bsf_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_top;
  import bsf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic        read_ok;
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] slot;
    logic [31:0] check;
    logic [31:0] cause_s;
    logic [31:0] cause_ns;
  } boot_event_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic        rec_ok;
    logic        write_back;
    logic [31:0] crc;
    logic        recovery;
    logic [7:0]  count;
    logic        halt;
  } boot_verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [191:0]         s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;

  // predictor copy of config and failover state
  logic [7:0]  cfg_first = 8'd97;
  logic [7:0]  cfg_last = 8'd98;
  logic [7:0]  cfg_limit = 8'd3;
  logic [31:0] cfg_none = 32'd0;
  logic [31:0] cfg_verify = 32'd1;
  logic [7:0]  known_slot = '0;
  logic [7:0]  start_slot = '0;
  logic [7:0]  fail_boots = '0;
  logic        rec_armed = 1'b0;
  // slot held in the stored record, used to build well-formed events
  logic [7:0]  flash_slot = 8'd97;

  boot_verdict_t verdict_q[$];
  boot_verdict_t want, got;
  logic [3:0]    got_pad;
  int unsigned   fail_cnt = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   stall_left = 0;
  bit            idle_on = 1'b1;

  boot_slot_failover_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int i = 0; i < 32; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] boot_record_crc(input logic [31:0] m, input logic [31:0] v,
                                                  input logic [31:0] s);
    return ~crc32_word(crc32_word(crc32_word(CRC_INIT, m), v), s);
  endfunction

  function automatic logic slot_valid(input logic [8:0] s);
    return (s >= {1'b0, cfg_first}) && (s <= {1'b0, cfg_last});
  endfunction

  task automatic predict_boot_decision(input boot_event_t ev);
    boot_verdict_t v;
    logic [7:0]    active;
    logic [8:0]    next;
    logic          ok, wb, hlt, advance;
    ok = ev.read_ok && ev.magic == REC_MAGIC && ev.version == REC_VERSION &&
         ev.check == boot_record_crc(ev.magic, ev.version, ev.slot) &&
         slot_valid({1'b0, ev.slot[7:0]});
    active = ev.slot[7:0];
    wb = 1'b0;
    hlt = 1'b0;
    if (!ok) begin
      active = (known_slot != 8'd0) ? known_slot : cfg_first;
      if (slot_valid({1'b0, active})) begin
        known_slot = active;
        wb = 1'b1;
      end
    end
    // starting slot is latched before the wrap compare
    if (start_slot == 8'd0) start_slot = active;
    if (ev.cause_s != cfg_none || ev.cause_ns != cfg_none) begin
      if (fail_boots != BYTE_MAX) fail_boots = fail_boots + 8'd1;
      advance = ev.cause_s == cfg_verify || ev.cause_ns == cfg_verify ||
                fail_boots >= cfg_limit;
      if (advance) begin
        next = {1'b0, active} + 9'd1;
        if (next > {1'b0, cfg_last}) next = {1'b0, cfg_first};
        if (slot_valid(next)) begin
          active = next[7:0];
          known_slot = next[7:0];
          wb = 1'b1;
        end
        fail_boots = '0;
        if (next == {1'b0, start_slot}) begin
          if (rec_armed) hlt = 1'b1;
          else rec_armed = 1'b1;
        end
      end
    end
    if (wb) flash_slot = active;
    v.slot = active;
    v.rec_ok = ok;
    v.write_back = wb;
    v.crc = boot_record_crc(REC_MAGIC, REC_VERSION, {24'd0, active});
    v.recovery = rec_armed;
    v.count = fail_boots;
    v.halt = hlt;
    verdict_q.push_back(v);
  endtask

  // ------------------------------------------------------------ event builders

  function automatic int unsigned pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
  endfunction

  function automatic boot_event_t good_record(input logic [7:0] s);
    boot_event_t ev;
    logic [23:0] upper;
    upper = $urandom_range(0, 1) ? 24'($urandom) : 24'd0;
    ev.read_ok = 1'b1;
    ev.magic = REC_MAGIC;
    ev.version = REC_VERSION;
    ev.slot = {upper, s};
    ev.check = boot_record_crc(REC_MAGIC, REC_VERSION, ev.slot);
    ev.cause_s = cfg_none;
    ev.cause_ns = cfg_none;
    return ev;
  endfunction

  function automatic logic [31:0] pick_cause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return cfg_none;
    if (r < 77) return cfg_verify;
    if (r < 90) return $urandom;
    return cfg_none ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  function automatic boot_event_t random_boot_event();
    boot_event_t ev;
    logic [7:0]  s;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) s = flash_slot;
    else if (r < 80 && cfg_first <= cfg_last) s = 8'($urandom_range(cfg_first, cfg_last));
    else s = 8'($urandom);
    ev = good_record(s);
    r = $urandom_range(0, 99);
    if (r < 75) begin
    end else if (r < 80) begin
      ev.read_ok = 1'b0;
    end else if (r < 84) begin
      ev.magic = ev.magic ^ (32'd1 << $urandom_range(0, 31));
    end else if (r < 88) begin
      ev.version = ev.version ^ (32'd1 << $urandom_range(0, 31));
    end else if (r < 94) begin
      ev.check = ev.check ^ (32'd1 << $urandom_range(0, 31));
    end else begin
      ev.read_ok = 1'($urandom);
      ev.magic = $urandom;
      ev.version = $urandom;
      ev.slot = $urandom;
      ev.check = $urandom;
    end
    ev.cause_s = pick_cause();
    ev.cause_ns = pick_cause();
    return ev;
  endfunction

  // ------------------------------------------------------------------ drivers

  task automatic send_event(input boot_event_t ev);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 99) < 30) ? pause_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ev.cause_ns, ev.cause_s, ev.check, ev.slot, ev.version, ev.magic};
    s_axis_tuser <= ev.read_ok;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_boot_decision(ev);
  endtask

  task automatic settle_pipeline();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      REG_SLOT_FIRST:   cfg_first = val[7:0];
      REG_SLOT_LAST:    cfg_last = val[7:0];
      REG_COUNT_LIMIT:  cfg_limit = val[7:0];
      REG_CAUSE_NONE:   cfg_none = val;
      REG_CAUSE_VERIFY: cfg_verify = val;
      default: ;
    endcase
  endtask

  // upper bits of the byte-wide registers carry junk that must be ignored
  task automatic apply_config(input logic [7:0] first, input logic [7:0] last,
                              input logic [7:0] limit, input logic [31:0] none_code,
                              input logic [31:0] verify_code);
    settle_pipeline();
    write_reg(REG_SLOT_FIRST, {24'($urandom), first});
    write_reg(REG_SLOT_LAST, {24'($urandom), last});
    write_reg(REG_COUNT_LIMIT, {24'($urandom), limit});
    write_reg(REG_CAUSE_NONE, none_code);
    write_reg(REG_CAUSE_VERIFY, verify_code);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left = pause_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.slot = m_axis_tdata[7:0];
      got.rec_ok = m_axis_tdata[8];
      got.write_back = m_axis_tdata[9];
      got.crc = m_axis_tdata[41:10];
      got.recovery = m_axis_tdata[42];
      got.count = m_axis_tdata[50:43];
      got.halt = m_axis_tdata[51];
      got_pad = m_axis_tdata[55:52];
      if (verdict_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("%0t: result transaction with nothing expected: %h", $realtime, m_axis_tdata);
      end else begin
        want = verdict_q.pop_front();
        if (got.slot != want.slot || got.rec_ok != want.rec_ok ||
            got.write_back != want.write_back || got.crc != want.crc ||
            got.recovery != want.recovery || got.count != want.count ||
            got.halt != want.halt || got_pad != 4'd0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX) begin
            $display("%0t: mismatch exp slot=%0d ok=%0b wb=%0b crc=%h rec=%0b cnt=%0d halt=%0b",
                     $realtime, want.slot, want.rec_ok, want.write_back, want.crc,
                     want.recovery, want.count, want.halt);
            $display("  got slot=%0d ok=%0b wb=%0b crc=%h rec=%0b cnt=%0d halt=%0b pad=%h",
                     got.slot, got.rec_ok, got.write_back, got.crc, got.recovery, got.count,
                     got.halt, got_pad);
          end
        end
      end
    end
  end

  // watchdog: cycles without any transaction on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------- tests

  task automatic test_record_checks();
    boot_event_t ev;
    send_event(good_record(8'd97));       // first event latches the starting slot
    send_event(good_record(8'd98));
    ev = good_record(8'd97);
    ev.read_ok = 1'b0;
    send_event(ev);
    ev = good_record(8'd98);
    ev.magic = ~REC_MAGIC;
    send_event(ev);
    ev = good_record(8'd97);
    ev.version = 32'h8000_0001;
    send_event(ev);
    ev = good_record(8'd98);
    ev.check = ev.check ^ 32'h0000_0100;
    send_event(ev);
    send_event(good_record(8'd99));       // valid CRC, slot above range
    ev = good_record(8'd96);               // valid CRC, slot below range
    ev.slot[31:8] = 24'hFFFFFF;
    ev.check = boot_record_crc(ev.magic, ev.version, ev.slot);
    send_event(ev);
    send_event('0);
    send_event('1);
  endtask

  task automatic test_failover_walk();
    boot_event_t ev;
    for (int i = 0; i < 3; i++) begin
      ev = good_record(flash_slot);
      ev.cause_s = 32'h0000_0002;
      send_event(ev);
    end
    ev = good_record(flash_slot);
    ev.cause_ns = cfg_verify;
    send_event(ev);
    ev = good_record(flash_slot);
    ev.cause_s = cfg_verify;
    send_event(ev);
    ev = good_record(flash_slot);
    ev.cause_s = cfg_verify;
    ev.cause_ns = cfg_verify;
    send_event(ev);
    ev = good_record(flash_slot);
    ev.cause_s = 32'hFFFF_FFFF;
    ev.cause_ns = 32'hFFFF_FFFF;
    send_event(ev);
    send_event(good_record(flash_slot));
    // keep wrapping until recovery is armed and then exhausted
    for (int i = 0; i < 4; i++) begin
      ev = good_record(flash_slot);
      ev.cause_ns = cfg_verify;
      send_event(ev);
    end
  endtask

  task automatic test_config_extremes();
    boot_event_t ev;
    apply_config(8'd1, 8'd255, 8'd1, 32'hFFFF_FFFF, 32'd0);
    repeat (150) send_event(random_boot_event());
    // single-slot window at the top: advancing from 255 wraps to itself
    apply_config(8'd255, 8'd255, 8'd2, 32'd0, 32'd1);
    repeat (60) send_event(random_boot_event());
    // inverted window: every record write is dropped
    apply_config(8'd200, 8'd100, 8'd1, 32'd0, 32'd1);
    repeat (60) send_event(random_boot_event());
    // count climbs all the way to the top limit before a switch
    apply_config(8'd10, 8'd12, 8'd255, 32'd0, 32'd1);
    for (int i = 0; i < 270; i++) begin
      ev = good_record(flash_slot);
      ev.cause_s = 32'h0000_0005;
      send_event(ev);
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0]  first, last, limit;
    logic [31:0] none_code, verify_code;
    for (int p = 0; p < 7; p++) begin
      first = 8'($urandom_range(1, 250));
      last = first + 8'($urandom_range(0, 5));
      if ($urandom_range(0, 4) == 0) last = 8'($urandom_range(1, 255));
      limit = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 5));
      none_code = $urandom_range(0, 1) ? 32'd0 : $urandom;
      verify_code = $urandom_range(0, 1) ? none_code + 32'd1 : $urandom;
      apply_config(first, last, limit, none_code, verify_code);
      idle_on = (p != 2);
      repeat (200) send_event(random_boot_event());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_record_checks();
    test_failover_walk();
    test_config_extremes();
    test_random_traffic();
    settle_pipeline();
    if (fail_cnt == 0 && verdict_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
